FILE: hdl/itoa_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_pkg
// Shared types, constants and helpers of the integer to ASCII converter.
// ----------------------------------------------------------------------------
package itoa_pkg;

  localparam int unsigned ValueBitsDef = 32;
  localparam int unsigned RadixBits    = 5;
  localparam int unsigned DigitBits    = 4;
  localparam int unsigned CharBits     = 7;

  localparam logic [RadixBits-1:0] MinRadix = RadixBits'(2);
  localparam logic [RadixBits-1:0] MaxRadix = RadixBits'(16);
  localparam logic [RadixBits-1:0] DecRadix = RadixBits'(10);

  localparam logic [CharBits-1:0] DigitBase  = CharBits'(48);
  localparam logic [CharBits-1:0] LetterBase = CharBits'(55);
  localparam logic [CharBits-1:0] MinusChar  = CharBits'(45);
  localparam logic [CharBits-1:0] ErrorChar  = CharBits'(0);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_SIGN,
    ST_READ,
    ST_EMIT,
    ST_ERR
  } itoa_state_e;

  typedef struct packed {
    logic push;
    logic pop;
  } stk_ctrl_t;

  function automatic logic [CharBits-1:0] digit_char(input logic [DigitBits-1:0] d);
    logic [CharBits-1:0] ext;
    ext = CharBits'(d);
    return (d < DigitBits'(10)) ? (ext + DigitBase) : (ext + LetterBase);
  endfunction

endpackage

FILE: hdl/itoa_if.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_in_if / itoa_out_if
// Valid/ready channels carrying the conversion request and the characters.
// ----------------------------------------------------------------------------
interface itoa_in_if #(
  parameter int unsigned VALUE_BITS = itoa_pkg::ValueBitsDef
);
  logic                                valid;
  logic                                ready;
  logic signed [VALUE_BITS-1:0]        value;
  logic [itoa_pkg::RadixBits-1:0]      radix;

  modport source (output valid, output value, output radix, input ready);
  modport sink   (input valid, input value, input radix, output ready);
endinterface

interface itoa_out_if;
  logic                                valid;
  logic                                ready;
  logic [itoa_pkg::CharBits-1:0]       character;
  logic                                last;
  logic                                bad_radix;

  modport source (output valid, output character, output last, output bad_radix,
                  input ready);
  modport sink   (input valid, input character, input last, input bad_radix,
                  output ready);
endinterface

FILE: hdl/itoa_digit_stack.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// itoa_digit_stack
// LIFO of digits: pushed least significant first, popped most significant
// first. Registered read data.
// ----------------------------------------------------------------------------
module itoa_digit_stack #(
  parameter int unsigned DEPTH = itoa_pkg::ValueBitsDef
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  itoa_pkg::stk_ctrl_t               ctrl_i,
  input  logic [itoa_pkg::DigitBits-1:0]    wdata_i,
  output logic [itoa_pkg::DigitBits-1:0]    rdata_o,
  output logic                              empty_o
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned SW = $clog2(DEPTH + 1);

  logic [itoa_pkg::DigitBits-1:0] mem [DEPTH];
  logic [SW-1:0]                  sp_q, sp_d;
  logic [SW-1:0]                  sp_dec;
  logic [itoa_pkg::DigitBits-1:0] rdata_q;

  assign sp_dec = sp_q - SW'(1);

  always_comb begin
    sp_d = sp_q;
    if (ctrl_i.push) begin
      sp_d = sp_q + SW'(1);
    end else if (ctrl_i.pop) begin
      sp_d = sp_dec;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sp_q <= '0;
    end else begin
      sp_q <= sp_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctrl_i.push) begin
      mem[sp_q[AW-1:0]] <= wdata_i;
    end
    if (ctrl_i.pop) begin
      rdata_q <= mem[sp_dec[AW-1:0]];
    end
  end

  assign rdata_o = rdata_q;
  assign empty_o = (sp_q == '0);

endmodule

FILE: hdl/integer_to_ascii_radix.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix
// Converts a signed integer to ASCII characters in radix 2 to 16.
// ----------------------------------------------------------------------------
// Usage:
//   in_bus  (sink): value and radix; one request beat per conversion.
//   out_bus (source): one beat per character, most significant digit first,
//   last set on the final beat. A radix outside 2..16 gives a single beat
//   with character 0, last and bad_radix set. Base 10 negatives start '-'.
// Timing:
//   Each digit comes from a bit-serial restoring division of the magnitude
//   by the radix, one quotient bit per cycle.
//   Digits go onto a LIFO and are popped most significant first, each
//   character passing through ST_READ and then ST_EMIT. One request is
//   worked at a time and in_bus.ready is high only when idle. An invalid
//   radix goes through ST_ERR, which loads the single error beat.
// Reset:
//   rst_ni clears the control state and the output valid; no clearing pass.
// Stall:
//   Results wait in the output register while out_bus.ready is low; the
//   states that load it (ST_ERR, ST_SIGN, ST_EMIT) hold until it frees up.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix #(
  parameter int unsigned VALUE_BITS = itoa_pkg::ValueBitsDef
) (
  input  logic       clk_i,
  input  logic       rst_ni,
  itoa_in_if.sink    in_bus,
  itoa_out_if.source out_bus
);

  localparam int unsigned CW = $clog2(VALUE_BITS);
  localparam int unsigned DB = itoa_pkg::DigitBits;
  localparam int unsigned RB = itoa_pkg::RadixBits;
  localparam int unsigned CB = itoa_pkg::CharBits;

  itoa_pkg::itoa_state_e state_q, state_d;

  logic [VALUE_BITS-1:0] mag_q;
  logic [RB-1:0]         radix_q;
  logic                  neg_q;
  logic [CW-1:0]         cnt_q;
  logic [DB-1:0]         rem_q;
  logic                  qnz_q;

  logic                  in_fire;
  logic                  in_bad;
  logic [RB-1:0]         trial;
  logic [RB-1:0]         trial_sub;
  logic                  qbit;
  logic [DB-1:0]         rem_next;
  logic                  div_last;
  logic                  quot_nz;

  itoa_pkg::stk_ctrl_t   stk_ctrl;
  logic [DB-1:0]         stk_rdata;
  logic                  stk_empty;

  logic                  out_valid_q;
  logic [CB-1:0]         char_q;
  logic                  last_q;
  logic                  bad_q;
  logic                  out_free;
  logic                  out_load;
  logic [CB-1:0]         load_char;
  logic                  load_last;
  logic                  load_bad;

  assign in_bus.ready = (state_q == itoa_pkg::ST_IDLE);
  assign in_fire      = in_bus.valid && in_bus.ready;
  assign in_bad       = (in_bus.radix < itoa_pkg::MinRadix) ||
                        (in_bus.radix > itoa_pkg::MaxRadix);
  assign out_free     = !out_valid_q || out_bus.ready;

  // one restoring division step
  assign trial     = {rem_q, mag_q[VALUE_BITS-1]};
  assign qbit      = (trial >= radix_q);
  assign trial_sub = trial - radix_q;
  assign rem_next  = qbit ? trial_sub[DB-1:0] : trial[DB-1:0];
  assign div_last  = (cnt_q == CW'(VALUE_BITS - 1));
  assign quot_nz   = qnz_q | qbit;

  always_comb begin
    state_d       = state_q;
    stk_ctrl      = '0;
    out_load      = 1'b0;
    load_char     = itoa_pkg::ErrorChar;
    load_last     = 1'b0;
    load_bad      = 1'b0;
    unique case (state_q)
      itoa_pkg::ST_IDLE: begin
        if (in_fire) begin
          state_d = in_bad ? itoa_pkg::ST_ERR : itoa_pkg::ST_DIV;
        end
      end
      itoa_pkg::ST_ERR: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_char = itoa_pkg::ErrorChar;
          load_last = 1'b1;
          load_bad  = 1'b1;
          state_d   = itoa_pkg::ST_IDLE;
        end
      end
      itoa_pkg::ST_DIV: begin
        if (div_last) begin
          stk_ctrl.push = 1'b1;
          if (!quot_nz) begin
            state_d = (neg_q && (radix_q == itoa_pkg::DecRadix)) ?
                      itoa_pkg::ST_SIGN : itoa_pkg::ST_READ;
          end
        end
      end
      itoa_pkg::ST_SIGN: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_char = itoa_pkg::MinusChar;
          state_d   = itoa_pkg::ST_READ;
        end
      end
      itoa_pkg::ST_READ: begin
        stk_ctrl.pop = 1'b1;
        state_d      = itoa_pkg::ST_EMIT;
      end
      itoa_pkg::ST_EMIT: begin
        if (out_free) begin
          out_load  = 1'b1;
          load_char = itoa_pkg::digit_char(stk_rdata);
          load_last = stk_empty;
          state_d   = stk_empty ? itoa_pkg::ST_IDLE : itoa_pkg::ST_READ;
        end
      end
      default: state_d = itoa_pkg::ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= itoa_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
      rem_q <= '0;
      qnz_q <= 1'b0;
    end else if (in_fire || (state_q == itoa_pkg::ST_DIV && div_last)) begin
      cnt_q <= '0;
      rem_q <= '0;
      qnz_q <= 1'b0;
    end else if (state_q == itoa_pkg::ST_DIV) begin
      cnt_q <= cnt_q + CW'(1);
      rem_q <= rem_next;
      qnz_q <= quot_nz;
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_fire) begin
      mag_q   <= in_bus.value[VALUE_BITS-1] ? (~in_bus.value + VALUE_BITS'(1))
                                            : in_bus.value;
      radix_q <= in_bus.radix;
      neg_q   <= in_bus.value[VALUE_BITS-1];
    end else if (state_q == itoa_pkg::ST_DIV) begin
      mag_q <= {mag_q[VALUE_BITS-2:0], qbit};
    end
  end

  itoa_digit_stack #(
    .DEPTH (VALUE_BITS)
  ) u_stack (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .ctrl_i  (stk_ctrl),
    .wdata_i (rem_next),
    .rdata_o (stk_rdata),
    .empty_o (stk_empty)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (out_load) begin
      out_valid_q <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (out_load) begin
      char_q <= load_char;
      last_q <= load_last;
      bad_q  <= load_bad;
    end
  end

  assign out_bus.valid     = out_valid_q;
  assign out_bus.character = char_q;
  assign out_bus.last      = last_q;
  assign out_bus.bad_radix = bad_q;

  a_bad_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && bad_q) |-> last_q)
    else $error("bad radix beat without last");

  a_idle_stack_empty: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_fire |-> stk_empty)
    else $error("request accepted with digits still stacked");

  a_push_only_dividing: assert property (@(posedge clk_i) disable iff (!rst_ni)
    stk_ctrl.push |=> (state_q == itoa_pkg::ST_DIV || state_q == itoa_pkg::ST_SIGN ||
                       state_q == itoa_pkg::ST_READ))
    else $error("unexpected state after digit push");

  a_last_ends_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_load && load_last) |=> (state_q == itoa_pkg::ST_IDLE))
    else $error("last beat loaded but converter not idle");

endmodule

FILE: verif/integer_to_ascii_radix_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_radix_test
// Drives conversion requests through the request channel and checks each
// character beat against an in-bench spelling of the value in its radix.
// Covers invalid radixes, zero, both extremes, every digit letter and the
// base 10 minus sign. Random traffic runs under several sender/receiver idling
// mixes plus one long receiver hold-off that backs the converter up.
// ----------------------------------------------------------------------------
module integer_to_ascii_radix_test;

  localparam int unsigned ValueBits     = itoa_pkg::ValueBitsDef;
  localparam int unsigned CharBits      = itoa_pkg::CharBits;
  localparam int unsigned RadixBits     = itoa_pkg::RadixBits;
  localparam int unsigned DigitBits     = itoa_pkg::DigitBits;
  localparam int unsigned HoldOffCycles = 1500;
  localparam int unsigned StuckLimit    = 20000;
  localparam int unsigned DrainCycles   = 60;
  localparam int unsigned ItemsPerPhase = 82;

  typedef struct packed {
    logic [CharBits-1:0] character;
    logic                last;
    logic                bad_radix;
  } char_beat_t;

  class itoa_scoreboard;
    char_beat_t  pending_chars[$];
    int unsigned mismatch_count = 0;
    int unsigned chars_checked  = 0;
    int unsigned requests_noted = 0;
    int unsigned bad_radix_seen = 0;
    int unsigned minus_seen     = 0;

    // spells the request into its expected character beats
    function void note_request(logic signed [ValueBits-1:0] value,
                               logic [RadixBits-1:0] radix);
      char_beat_t           beat;
      logic [ValueBits-1:0] mag;
      logic [DigitBits-1:0] digits[$];
      logic [DigitBits-1:0] d;
      requests_noted++;
      if (radix < itoa_pkg::MinRadix || radix > itoa_pkg::MaxRadix) begin
        beat.character = itoa_pkg::ErrorChar;
        beat.last      = 1'b1;
        beat.bad_radix = 1'b1;
        pending_chars.push_back(beat);
        bad_radix_seen++;
        return;
      end
      mag = value[ValueBits-1] ? (~value + 1'b1) : value;
      do begin
        digits.push_front(DigitBits'(mag % ValueBits'(radix)));
        mag = mag / ValueBits'(radix);
      end while (mag != '0);
      if (value[ValueBits-1] && radix == itoa_pkg::DecRadix) begin
        beat.character = itoa_pkg::MinusChar;
        beat.last      = 1'b0;
        beat.bad_radix = 1'b0;
        pending_chars.push_back(beat);
        minus_seen++;
      end
      foreach (digits[i]) begin
        d = digits[i];
        beat.character = (d < 4'd10) ? (CharBits'(d) + itoa_pkg::DigitBase)
                                     : (CharBits'(d) + itoa_pkg::LetterBase);
        beat.last      = (i == digits.size() - 1);
        beat.bad_radix = 1'b0;
        pending_chars.push_back(beat);
      end
    endfunction

    function void check_char(logic [CharBits-1:0] character, logic last, logic bad_radix);
      char_beat_t want;
      chars_checked++;
      if (pending_chars.size() == 0) begin
        $error("unexpected character beat: character %0d last %0d bad_radix %0d",
               character, last, bad_radix);
        mismatch_count++;
        return;
      end
      want = pending_chars.pop_front();
      if (character !== want.character) begin
        $error("character: expected %0d, got %0d", want.character, character);
        mismatch_count++;
      end
      if (last !== want.last) begin
        $error("last: expected %0d, got %0d", want.last, last);
        mismatch_count++;
      end
      if (bad_radix !== want.bad_radix) begin
        $error("bad_radix: expected %0d, got %0d", want.bad_radix, bad_radix);
        mismatch_count++;
      end
    endfunction
  endclass

  logic clk   = 1'b0;
  logic rst_n = 1'b0;

  itoa_in_if #(.VALUE_BITS(ValueBits)) req_bus ();
  itoa_out_if                          char_bus ();

  itoa_scoreboard sb = new;

  int unsigned send_idle_pct     = 0;
  int unsigned sink_stall_pct    = 0;
  int unsigned hold_off_requests = 0;
  int unsigned stuck_cycles      = 0;

  integer_to_ascii_radix #(.VALUE_BITS(ValueBits)) dut (
    .clk_i   (clk),
    .rst_ni  (rst_n),
    .in_bus  (req_bus),
    .out_bus (char_bus)
  );

  always #6 clk = ~clk;

  task automatic send_request(logic signed [ValueBits-1:0] value,
                              logic [RadixBits-1:0] radix);
    while ($urandom_range(99) < send_idle_pct) begin
      req_bus.valid <= 1'b0;
      @(posedge clk);
    end
    req_bus.valid <= 1'b1;
    req_bus.value <= value;
    req_bus.radix <= radix;
    @(posedge clk);
    while (!req_bus.ready) @(posedge clk);
    sb.note_request(value, radix);
  endtask

  function automatic logic signed [ValueBits-1:0] pick_value();
    logic signed [ValueBits-1:0] v;
    case ($urandom_range(3))
      0: v = $urandom;
      1: v = $urandom >> $urandom_range(ValueBits - 1);
      2: v = $urandom_range(300);
      default: begin
        case ($urandom_range(4))
          0: v = '0;
          1: v = 1;
          2: v = {1'b1, {(ValueBits-1){1'b0}}};
          3: v = {1'b0, {(ValueBits-1){1'b1}}};
          default: v = '1;
        endcase
      end
    endcase
    if ($urandom_range(1) == 1) v = -v;
    return v;
  endfunction

  function automatic logic [RadixBits-1:0] pick_radix();
    int unsigned r;
    if ($urandom_range(99) >= 12)
      return RadixBits'($urandom_range(itoa_pkg::MaxRadix, itoa_pkg::MinRadix));
    r = $urandom_range(16);
    return (r < itoa_pkg::MinRadix) ? RadixBits'(r) : RadixBits'(r + itoa_pkg::MaxRadix - 1);
  endfunction

  // receiver: random stalls plus the requested long hold-off
  initial begin : char_sink
    int unsigned hold_left;
    int unsigned holds_taken;
    hold_left   = 0;
    holds_taken = 0;
    char_bus.ready <= 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && char_bus.valid && char_bus.ready)
        sb.check_char(char_bus.character, char_bus.last, char_bus.bad_radix);
      if (hold_off_requests != holds_taken) begin
        holds_taken = hold_off_requests;
        hold_left   = HoldOffCycles;
      end
      if (hold_left != 0) begin
        hold_left--;
        char_bus.ready <= 1'b0;
      end else begin
        char_bus.ready <= ($urandom_range(99) >= sink_stall_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (rst_n) begin
      if ((req_bus.valid && req_bus.ready) || (char_bus.valid && char_bus.ready)) begin
        stuck_cycles <= 0;
      end else if (stuck_cycles >= StuckLimit) begin
        $display("watchdog: no beat for %0d cycles", stuck_cycles);
        $display("end of test: mismatches");
        $finish;
      end else begin
        stuck_cycles <= stuck_cycles + 1;
      end
    end
  end

  initial begin : stimulus
    int unsigned idle_mix[4];
    int unsigned stall_mix[4];
    idle_mix  = '{0, 66, 0, 34};
    stall_mix = '{0, 0, 66, 34};
    req_bus.valid <= 1'b0;
    req_bus.value <= '0;
    req_bus.radix <= '0;
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // directed corners
    send_request(123, 0);
    send_request(-5, 1);
    send_request(77, 17);
    send_request('1, 31);
    send_request(0, 10);
    send_request(0, 2);
    send_request({1'b1, {(ValueBits-1){1'b0}}}, 10);
    send_request({1'b1, {(ValueBits-1){1'b0}}}, 2);
    send_request({1'b1, {(ValueBits-1){1'b0}}}, 16);
    send_request({1'b0, {(ValueBits-1){1'b1}}}, 10);
    send_request({1'b0, {(ValueBits-1){1'b1}}}, 2);
    send_request({1'b0, {(ValueBits-1){1'b1}}}, 16);
    send_request(-1, 10);
    send_request(-1, 16);
    send_request(32'h0123_4567, 16);
    send_request(32'h89AB_CDEF, 16);
    send_request(-12345, 8);
    send_request(255, 3);
    send_request(12, 13);
    send_request(-999, 7);
    send_request(9, 10);
    send_request(1, 5);

    foreach (idle_mix[p]) begin
      send_idle_pct  = idle_mix[p];
      sink_stall_pct = stall_mix[p];
      repeat (ItemsPerPhase) send_request(pick_value(), pick_radix());
    end

    // back-pressure: receiver parks while requests keep coming
    send_idle_pct  = 0;
    sink_stall_pct = 0;
    hold_off_requests++;
    repeat (14) send_request($urandom_range(5000), pick_radix());
    req_bus.valid <= 1'b0;

    while (sb.pending_chars.size() != 0) @(posedge clk);
    repeat (DrainCycles) @(posedge clk);

    $display("converted %0d requests (%0d with bad radix, %0d signed decimal)",
             sb.requests_noted, sb.bad_radix_seen, sb.minus_seen);
    $display("checked %0d character beats across four idling mixes and a long hold-off",
             sb.chars_checked);
    if (sb.mismatch_count == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule

FILE: filelist.f
hdl/itoa_pkg.sv
hdl/itoa_if.sv
hdl/itoa_digit_stack.sv
hdl/integer_to_ascii_radix.sv
verif/integer_to_ascii_radix_test.sv
